/* hw/rtl/pms_pkg.sv */
// Package for the power-mode supervisor: types, codes and reset constants.
`timescale 1ns / 1ps

package pms_pkg;

  // Operating modes
  typedef enum logic [1:0] {
    MODE_RUNNING = 2'd0,
    MODE_CHARGE  = 2'd1,
    MODE_BATWAIT = 2'd2,
    MODE_SLEEP   = 2'd3
  } mode_t;

  // Action codes reported with each result
  typedef enum logic [2:0] {
    ACT_NONE         = 3'd0,
    ACT_SLEEP        = 3'd1,
    ACT_HOLD_BATWAIT = 3'd2,
    ACT_HOLD_CHARGE  = 3'd3,
    ACT_RESET        = 3'd4
  } action_t;

  // Item kinds
  typedef enum logic {
    KIND_BOOT   = 1'b0,
    KIND_UPDATE = 1'b1
  } kind_t;

  // Configuration register indexes
  typedef enum logic [1:0] {
    CFG_DEBOUNCE  = 2'd0,
    CFG_IDLE_MIN  = 2'd1,
    CFG_CUTOFF_MV = 2'd2,
    CFG_CHARGE_EN = 2'd3
  } cfg_index_t;

  localparam int unsigned TimeW     = 32;
  localparam int unsigned MvW       = 13;
  localparam int unsigned DebounceW = 16;
  localparam int unsigned MinutesW  = 8;
  localparam int unsigned MsPerMinW = 16;
  localparam int unsigned TimeoutW  = MinutesW + MsPerMinW;
  localparam int unsigned CfgDataW  = 16;

  localparam logic [MsPerMinW-1:0] MS_PER_MINUTE    = 16'd60000;
  localparam logic [DebounceW-1:0] DEBOUNCE_RST     = 16'd200;
  localparam logic [MinutesW-1:0]  IDLE_MIN_RST     = 8'd10;
  localparam logic [MvW-1:0]       CUTOFF_MV_RST    = 13'd3300;
  localparam logic                 CHARGE_EN_RST    = 1'b0;
  localparam logic [TimeoutW-1:0]  IDLE_TIMEOUT_RST = 24'd600000;

  typedef struct packed {
    logic             kind;
    logic [TimeW-1:0] now_ms;
    logic             switch_on;
    logic             usb_present;
    logic [MvW-1:0]   battery_mv;
    logic             cutoff_request;
    logic             client_subscribed;
  } item_t;

  typedef struct packed {
    mode_t   mode;
    action_t action;
  } result_t;

  typedef struct packed {
    cfg_index_t          index;
    logic [CfgDataW-1:0] wdata;
  } cfg_write_t;

  // Settings handed from the register file to the decision logic
  typedef struct packed {
    logic [DebounceW-1:0] debounce_ms;
    logic [TimeoutW-1:0]  idle_timeout_ms;
    logic [MvW-1:0]       cutoff_mv;
    logic                 charge_en;
  } cfg_t;

endpackage

/* hw/rtl/pms_stream_if.sv */
// Valid/ready channel interface carrying one payload per transaction.
`timescale 1ns / 1ps

interface pms_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* hw/rtl/pms_cfg_regs.sv */
// Configuration register file with the idle timeout kept in milliseconds.
`timescale 1ns / 1ps

module pms_cfg_regs (
  input  logic                       clk,
  input  logic                       rst,
  pms_stream_if.sink                 cfg,
  output pms_pkg::cfg_t              settings
);

  logic                         wr;

  assign cfg.ready = 1'b1;
  assign wr        = cfg.valid;

  // Register writes; the timeout product is formed here once per write
  always_ff @(posedge clk) begin
    if (rst) begin
      settings.debounce_ms     <= pms_pkg::DEBOUNCE_RST;
      settings.idle_timeout_ms <= pms_pkg::IDLE_TIMEOUT_RST;
      settings.cutoff_mv       <= pms_pkg::CUTOFF_MV_RST;
      settings.charge_en       <= pms_pkg::CHARGE_EN_RST;
    end else if (wr) begin
      unique case (cfg.data.index)
        pms_pkg::CFG_DEBOUNCE: begin
          settings.debounce_ms <= cfg.data.wdata[pms_pkg::DebounceW-1:0];
        end
        pms_pkg::CFG_IDLE_MIN: begin
          settings.idle_timeout_ms <=
            {{(pms_pkg::TimeoutW-pms_pkg::MinutesW){1'b0}},
             cfg.data.wdata[pms_pkg::MinutesW-1:0]}
            * {{(pms_pkg::TimeoutW-pms_pkg::MsPerMinW){1'b0}}, pms_pkg::MS_PER_MINUTE};
        end
        pms_pkg::CFG_CUTOFF_MV: begin
          settings.cutoff_mv <= cfg.data.wdata[pms_pkg::MvW-1:0];
        end
        pms_pkg::CFG_CHARGE_EN: begin
          settings.charge_en <= cfg.data.wdata[0];
        end
      endcase
    end
  end

endmodule

/* hw/rtl/pms_core.sv */
// Mode state, timestamp anchors and the per-item decision logic.
`timescale 1ns / 1ps

module pms_core (
  input  logic             clk,
  input  logic             rst,
  input  logic             fire,
  input  pms_pkg::item_t   item,
  input  pms_pkg::cfg_t    settings,
  output pms_pkg::result_t res
);

  pms_pkg::mode_t              mode_reg, mode_next;
  logic [pms_pkg::TimeW-1:0]   sw_anchor, sw_anchor_next;
  logic [pms_pkg::TimeW-1:0]   idle_anchor, idle_anchor_next;
  logic [pms_pkg::TimeW-1:0]   sw_eff, idle_eff, sw_elapsed, idle_elapsed;
  logic                        held_on, timed_out;
  pms_pkg::action_t            action;

  // Anchor that starts counting now if its clock is stopped
  assign sw_eff       = (sw_anchor == '0) ? item.now_ms : sw_anchor;
  assign idle_eff     = (idle_anchor == '0) ? item.now_ms : idle_anchor;
  assign sw_elapsed   = item.now_ms - sw_eff;
  assign idle_elapsed = item.now_ms - idle_eff;
  assign held_on      = item.switch_on ||
                        (sw_elapsed < {{(pms_pkg::TimeW-pms_pkg::DebounceW){1'b0}},
                                       settings.debounce_ms});
  assign timed_out    = idle_elapsed >=
                        {{(pms_pkg::TimeW-pms_pkg::TimeoutW){1'b0}},
                         settings.idle_timeout_ms};

  // Next mode, anchors and action
  always_comb begin
    mode_next        = mode_reg;
    sw_anchor_next   = sw_anchor;
    idle_anchor_next = idle_anchor;
    action           = pms_pkg::ACT_NONE;
    if (item.kind == pms_pkg::KIND_BOOT) begin
      sw_anchor_next   = '0;
      idle_anchor_next = '0;
      priority if (!item.switch_on) begin
        mode_next = pms_pkg::MODE_BATWAIT;
      end else if (!item.usb_present && (item.battery_mv < settings.cutoff_mv)) begin
        mode_next = pms_pkg::MODE_SLEEP;
        action    = pms_pkg::ACT_SLEEP;
      end else if (item.usb_present && settings.charge_en) begin
        mode_next = pms_pkg::MODE_CHARGE;
      end else begin
        mode_next = pms_pkg::MODE_RUNNING;
      end
    end else begin
      unique case (mode_reg)
        pms_pkg::MODE_RUNNING: begin
          if (!(item.cutoff_request && !item.usb_present)) begin
            sw_anchor_next = item.switch_on ? '0 : sw_eff;
          end
          priority if (item.cutoff_request && !item.usb_present) begin
            mode_next = pms_pkg::MODE_SLEEP;
            action    = pms_pkg::ACT_SLEEP;
          end else if (!held_on) begin
            mode_next = pms_pkg::MODE_BATWAIT;
            action    = pms_pkg::ACT_HOLD_BATWAIT;
          end else if (settings.charge_en && item.usb_present) begin
            mode_next = pms_pkg::MODE_CHARGE;
            action    = pms_pkg::ACT_HOLD_CHARGE;
          end else if (item.client_subscribed || item.usb_present) begin
            idle_anchor_next = '0;
          end else begin
            idle_anchor_next = idle_eff;
            if (timed_out) begin
              mode_next = pms_pkg::MODE_SLEEP;
              action    = pms_pkg::ACT_SLEEP;
            end
          end
        end
        pms_pkg::MODE_CHARGE: begin
          if (!item.usb_present) begin
            action = pms_pkg::ACT_RESET;
          end else begin
            sw_anchor_next = item.switch_on ? '0 : sw_eff;
            if (!held_on) action = pms_pkg::ACT_RESET;
          end
        end
        pms_pkg::MODE_BATWAIT: begin
          if (item.switch_on) action = pms_pkg::ACT_RESET;
        end
        pms_pkg::MODE_SLEEP: begin
          action = pms_pkg::ACT_NONE;
        end
      endcase
    end
  end

  assign res.mode   = mode_next;
  assign res.action = action;

  // State commits when the item moves into the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      mode_reg    <= pms_pkg::MODE_RUNNING;
      sw_anchor   <= '0;
      idle_anchor <= '0;
    end else if (fire) begin
      mode_reg    <= mode_next;
      sw_anchor   <= sw_anchor_next;
      idle_anchor <= idle_anchor_next;
    end
  end

endmodule

/* hw/rtl/power_mode_supervisor.sv */
// Power-mode supervisor: one result per item, input register to result register.
// Each item is held in the input register, then its result in the result register.
// Throughput: one item per cycle while the result is taken; the mode/anchor update is combinational.
// Input stalls only when both registers are full and the result is not being taken.
// Reset (rst, synchronous): mode running, both anchors stopped, registers at defaults.
`timescale 1ns / 1ps

module power_mode_supervisor (
  input  logic       clk,
  input  logic       rst,
  pms_stream_if.sink   item,
  pms_stream_if.source result,
  pms_stream_if.sink   cfg
);

  logic             s1_valid;
  pms_pkg::item_t   s1_item;
  logic             s1_advance;
  logic             out_valid;
  pms_pkg::result_t out_data;
  pms_pkg::result_t core_res;
  pms_pkg::cfg_t    settings;

  pms_cfg_regs u_cfg (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .settings (settings)
  );

  pms_core u_core (
    .clk      (clk),
    .rst      (rst),
    .fire     (s1_advance),
    .item     (s1_item),
    .settings (settings),
    .res      (core_res)
  );

  // Pipeline flow control
  assign s1_advance = s1_valid && (!out_valid || result.ready);
  assign item.ready = !s1_valid || s1_advance;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (item.ready) begin
      s1_valid <= item.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item.valid && item.ready) s1_item <= item.data;
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_advance) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_advance) out_data <= core_res;
  end

  assign result.valid = out_valid;
  assign result.data  = out_data;

`ifndef SYNTHESIS
  a_sleep_mode: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.action == pms_pkg::ACT_SLEEP)
      |-> out_data.mode == pms_pkg::MODE_SLEEP)
    else $error("sleep action without deep-sleep mode");

  a_hold_mode: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.action == pms_pkg::ACT_HOLD_BATWAIT)
      |-> out_data.mode == pms_pkg::MODE_BATWAIT)
    else $error("battery-wait hold without battery-wait mode");

  a_reset_mode: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.action == pms_pkg::ACT_RESET)
      |-> (out_data.mode == pms_pkg::MODE_CHARGE || out_data.mode == pms_pkg::MODE_BATWAIT))
    else $error("reset request from a mode that cannot issue it");

  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    !item.ready |-> (s1_valid && out_valid && !result.ready))
    else $error("input stalled while pipeline has room");
`endif

endmodule
